@@ hdl/assert_macros.svh @@
// Assertion macros shared by the dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPCD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SPCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SPCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hdl/spcd_pkg.sv @@
// Types, constants and helpers for the strict priority call dispatcher.
`default_nettype none
package spcd_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CLASS_COUNT = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CLS_W       = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int ADDR_W      = CLS_W + PTR_W;
  localparam int MEM_DEPTH   = CLASS_COUNT * (2 ** PTR_W);
  localparam int ID_W        = 16;
  localparam int DUR_W       = 16;
  localparam int CMDQ_DEPTH  = 2;
  localparam int QPTR_W      = $clog2(CMDQ_DEPTH);
  localparam int QCNT_W      = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic {
    MODE_ARRIVAL = 1'b0,
    MODE_TICK    = 1'b1
  } mode_e;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_e;

  typedef struct packed {
    logic             mode;
    logic [1:0]       caller_class;
    logic [ID_W-1:0]  caller_id;
    logic [DUR_W-1:0] service_ticks;
  } req_t;

  typedef struct packed {
    logic            answered;
    logic [ID_W-1:0] answered_id;
    logic [1:0]      answered_class;
    logic            server_busy;
    logic            all_idle;
    logic            arrival_dropped;
  } rsp_t;

  typedef struct packed {
    mode_e            mode;
    logic [CLS_W-1:0] cls;
    logic [ID_W-1:0]  id;
    logic [DUR_W-1:0] dur;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [DUR_W-1:0] dur;
  } entry_t;

  function automatic logic [CLS_W-1:0] clamp_class(input logic [1:0] c);
    logic [CLS_W-1:0] r;
    if (int'(c) >= CLASS_COUNT) begin
      r = CLS_W'(CLASS_COUNT - 1);
    end else begin
      r = CLS_W'(c);
    end
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/strict_priority_call_dispatcher.sv @@
// Arrival, counting tick: command queue, then result register; answering tick adds the store read.
// Throughput: one beat per cycle, but an answering tick holds the back end in its store read.
// busy_o rises when the 2-entry command queue is full; results cannot be stalled.
// Reset clears queue pointers, fill counts, service counter and control; store contents stay
// undefined and need no clearing pass.
`default_nettype none
module strict_priority_call_dispatcher import spcd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire req_t req_i,
  output logic      busy_o,
  output logic      done_o,
  output rsp_t      rsp_o
);

  cmdq_t cmdq;
  logic  pop;

  spcd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .pop_i  (pop),
    .cmd_o  (cmdq)
  );

  spcd_back u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmdq),
    .pop_o (pop),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

endmodule
`default_nettype wire

@@ hdl/spcd_front.sv @@
// Front end: accepts beats, classifies them and holds them in a short command queue.
`default_nettype none
`include "assert_macros.svh"
module spcd_front import spcd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire req_t  req_i,
  output logic       busy_o,
  input  wire logic  pop_i,
  output cmdq_t      cmd_o
);

  cmd_t              buf_q [CMDQ_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;
  cmd_t              cmd_in;

  assign busy_o = (count_q == QCNT_W'(CMDQ_DEPTH));
  assign push   = start_i && !busy_o;

  always_comb begin
    cmd_in.mode = req_i.mode ? MODE_TICK : MODE_ARRIVAL;
    cmd_in.cls  = clamp_class(req_i.caller_class);
    cmd_in.id   = req_i.caller_id;
    cmd_in.dur  = req_i.service_ticks;
  end

  always_comb begin
    wr_d    = push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d    = pop_i ? rd_q + QPTR_W'(1) : rd_q;
    count_d = count_q + QCNT_W'(push) - QCNT_W'(pop_i);
  end

  assign cmd_o.valid = (count_q != '0);
  assign cmd_o.cmd   = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  `SPCD_ASSERT(a_cmdq_bound, clk_i, rst_ni, count_q <= QCNT_W'(CMDQ_DEPTH), "command queue overflow")
  `SPCD_ASSERT(a_pop_nonempty, clk_i, rst_ni, !pop_i || (count_q != '0), "pop from empty command queue")

endmodule
`default_nettype wire

@@ hdl/spcd_back.sv @@
// Back end: class queues, priority selection, service counter and result register.
`default_nettype none
`include "assert_macros.svh"
module spcd_back import spcd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmdq_t cmd_i,
  output logic       pop_o,
  output logic       done_o,
  output rsp_t       rsp_o
);

  entry_t            mem_q [MEM_DEPTH];
  entry_t            rd_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  entry_t            wdata;

  logic [PTR_W-1:0]  head_q [CLASS_COUNT];
  logic [PTR_W-1:0]  head_d [CLASS_COUNT];
  logic [PTR_W-1:0]  tail_q [CLASS_COUNT];
  logic [PTR_W-1:0]  tail_d [CLASS_COUNT];
  logic [CNT_W-1:0]  cnt_q  [CLASS_COUNT];
  logic [CNT_W-1:0]  cnt_d  [CLASS_COUNT];
  logic [DUR_W-1:0]  rem_q, rem_d;
  logic [CLS_W-1:0]  sel_q, sel_d, pick;
  logic              any_ne, none_left, drop;
  back_state_e       state_q, state_d;
  rsp_t              rsp_q, rsp_d;
  logic              done_q, done_d;
  logic              start_pop;

  always_comb begin
    pick   = '0;
    any_ne = 1'b0;
    for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
      if (cnt_q[c] != '0) begin
        pick   = CLS_W'(c);
        any_ne = 1'b1;
      end
    end
  end

  assign start_pop = (state_q == BK_IDLE) && cmd_i.valid && (cmd_i.cmd.mode == MODE_TICK)
                     && (rem_q == '0) && any_ne;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (start_pop) begin
          state_d = BK_READ;
        end
      end
      BK_READ: begin
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o  = 1'b0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = {cmd_i.cmd.cls, tail_q[cmd_i.cmd.cls]};
    raddr  = {pick, head_q[pick]};
    wdata.id  = cmd_i.cmd.id;
    wdata.dur = cmd_i.cmd.dur;
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sel_d  = sel_q;
    drop   = 1'b0;
    done_d = 1'b0;
    rsp_d  = '0;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_i.valid) begin
          pop_o  = 1'b1;
          done_d = 1'b1;
          if (cmd_i.cmd.mode == MODE_ARRIVAL) begin
            if (cnt_q[cmd_i.cmd.cls] == CNT_W'(QUEUE_DEPTH)) begin
              drop = 1'b1;
            end else begin
              mem_we = 1'b1;
              tail_d[cmd_i.cmd.cls] = ptr_next(tail_q[cmd_i.cmd.cls]);
              cnt_d[cmd_i.cmd.cls]  = cnt_q[cmd_i.cmd.cls] + CNT_W'(1);
            end
          end else if (rem_q != '0) begin
            rem_d = rem_q - DUR_W'(1);
          end else if (any_ne) begin
            mem_re       = 1'b1;
            done_d       = 1'b0;
            head_d[pick] = ptr_next(head_q[pick]);
            cnt_d[pick]  = cnt_q[pick] - CNT_W'(1);
            sel_d        = pick;
          end
        end
      end
      BK_READ: begin
        done_d               = 1'b1;
        rem_d                = (rd_q.dur == '0) ? '0 : rd_q.dur - DUR_W'(1);
        rsp_d.answered       = 1'b1;
        rsp_d.answered_id    = rd_q.id;
        rsp_d.answered_class = 2'(sel_q);
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
    none_left = 1'b1;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if (cnt_d[c] != '0) begin
        none_left = 1'b0;
      end
    end
    rsp_d.server_busy     = (rem_d != '0);
    rsp_d.all_idle        = (rem_d == '0) && none_left;
    rsp_d.arrival_dropped = drop;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      rem_q   <= '0;
      done_q  <= 1'b0;
      for (int c = 0; c < CLASS_COUNT; c++) begin
        head_q[c] <= '0;
        tail_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      done_q  <= done_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `SPCD_ASSERT(a_busy_match, clk_i, rst_ni, !done_q || (rsp_q.server_busy == (rem_q != '0)), "server_busy disagrees with counter")
  `SPCD_ASSERT_NEXT(a_read_answers, clk_i, rst_ni, state_q == BK_READ, done_q && rsp_q.answered, "pop did not answer")
  `SPCD_ASSERT(a_pop_has_entry, clk_i, rst_ni, !mem_re || (cnt_q[pick] != '0), "pop from empty class queue")

endmodule
`default_nettype wire
